[hdl/xlb_pkg.sv]
package xlb_pkg;

    // Vector width and number of basis slots (one slot per leading bit)
    localparam int WIDTH = 63;
    localparam int IDX_W = $clog2(WIDTH);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(WIDTH - 1);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed
    {
        logic load;
        logic prime;
        logic step;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic last;
        logic stored;
        logic is_query;
        logic out_free;
    } dp_status_t;

endpackage

[hdl/xor_linear_basis_top.sv]
// Channel  Handshake             Payload
// input    in_valid / in_ready   cmd (1), value (63)
// output   out_valid / out_ready max_xor (63)
//
// One item at a time: accept, prime the slot read, then one slot
// per cycle from bit 62 down, set by the single read port of the basis memory.
// A query ends by emitting its result; an insert ends at the slot it fills, or after slot 0.
// Reset clears the slot valid flags at once; no clearing pass.
// A finished query waits in the output register; a new item is taken meanwhile,
// and only a second query result stalls until the first is taken.
module xor_linear_basis_top
    import xlb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cmd,
    input  logic [WIDTH-1:0] value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] max_xor
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    xlb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    xlb_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .in_cmd    (cmd),
        .in_value  (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (max_xor)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again straight after an accept");

    a_emit_query_only: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.emit |-> dp_status.is_query)
        else $error("result emitted for an insert");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(dp_cmd.emit))
        else $error("result appeared without an emit");

    a_no_step_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !dp_cmd.step && !dp_cmd.emit)
        else $error("datapath worked while idle");

endmodule

[hdl/xlb_ctrl.sv]
module xlb_ctrl
    import xlb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                // an insert stops at the slot that takes it
                if (status.stored)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.last)
                begin
                    state_next = status.is_query ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/xlb_datapath.sv]
module xlb_datapath
    import xlb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic             in_cmd,
    input  logic [WIDTH-1:0] in_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_value
);

    logic [WIDTH-1:0] basis_mem [WIDTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [WIDTH-1:0] slot_valid_reg;
    logic [WIDTH-1:0] slot_valid_next;
    logic [WIDTH-1:0] value_reg;
    logic [WIDTH-1:0] value_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] rd_addr;
    op_t              op_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] max_xor_reg;
    logic             slot_full;
    logic             lead_bit;
    logic             wr_en;

    assign slot_full = slot_valid_reg[idx_reg];
    assign lead_bit  = value_reg[idx_reg];
    assign wr_en     = cmd.step && (op_reg == OP_INSERT) && lead_bit && !slot_full;

    // Prime fetches the current slot, a walk step fetches the one below (slot 0 refetches itself)
    always_comb
    begin
        if (cmd.prime || (idx_reg == '0))
        begin
            rd_addr = idx_reg;
        end
        else
        begin
            rd_addr = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            basis_mem[idx_reg] <= value_reg;
        end
        rd_data_reg <= basis_mem[rd_addr];
    end

    always_comb
    begin
        value_next      = value_reg;
        idx_next        = idx_reg;
        slot_valid_next = slot_valid_reg;
        if (cmd.load)
        begin
            value_next = in_value;
            idx_next   = TOP_IDX;
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg - 1'b1;
            if (op_reg == OP_INSERT)
            begin
                if (lead_bit && slot_full)
                begin
                    value_next = value_reg ^ rd_data_reg;
                end
                else if (lead_bit)
                begin
                    slot_valid_next[idx_reg] = 1'b1;
                end
            end
            else if (slot_full && !lead_bit)
            begin
                // slot vector leads at this bit, so xoring it in raises the value
                value_next = value_reg ^ rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        idx_reg   <= idx_next;
        if (cmd.load)
        begin
            op_reg <= op_t'(in_cmd);
        end
        if (cmd.emit)
        begin
            max_xor_reg <= value_reg;
        end
    end

    assign status.last     = (idx_reg == '0);
    assign status.stored   = wr_en;
    assign status.is_query = (op_reg == OP_QUERY);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = max_xor_reg;

endmodule
